// ===== hw/rtl/lcs_pkg.sv =====
// shared constants and types for the linear congruence solver
package lcs_pkg;

  localparam int unsigned StateW = 3;

  localparam logic [StateW-1:0] ST_IDLE = 3'd0;
  localparam logic [StateW-1:0] ST_GCD  = 3'd1;
  localparam logic [StateW-1:0] ST_DIV  = 3'd2;
  localparam logic [StateW-1:0] ST_EUC  = 3'd3;
  localparam logic [StateW-1:0] ST_MUL  = 3'd4;
  localparam logic [StateW-1:0] ST_DONE = 3'd5;

  // register index of the modulus
  localparam int unsigned RegModulus = 0;

  // what the divider result is used for
  typedef enum logic [2:0] {
    OP_GCD   = 3'd0,
    OP_RED_P = 3'd1,
    OP_RED_M = 3'd2,
    OP_RED_Q = 3'd3,
    OP_QMOD  = 3'd4,
    OP_EUC   = 3'd5
  } div_op_t;

endpackage

// ===== hw/rtl/linear_congruence_solver.sv =====
// linear congruence solver: gcd reduction, extended euclid, modular multiply
// one bit-serial restoring divider serves the gcd and euclid division steps and the
//   reductions by the gcd; the modular multiply is bit-serial too; a zero modulus
//   skips straight to the result
// throughput: one word at a time, the next word is taken the cycle after the result
//   is loaded into the output register; a result waiting there only blocks the next load
// reset: synchronous, active high; modulus returns to 1, control to idle, no result pending
module linear_congruence_solver #(
  parameter int unsigned VALUE_WIDTH = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] multiplier,
  input  logic [VALUE_WIDTH-1:0] target,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] solution,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import lcs_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0] modulus;
  logic [StateW-1:0] state;
  div_op_t op;
  logic phase;

  logic [W-1:0] p, q, m;
  logic [W-1:0] r0, r1;
  logic signed [W+1:0] s0, s1, prod;
  logic [W-1:0] qgm;
  logic neg;
  logic [W-1:0] mag, acc;

  // divider: dd shifts the dividend out and the quotient in, dr is the partial remainder
  logic [W-1:0] dd, dr, dv;
  logic [CW-1:0] cnt;

  assign pready = 1'b1;
  assign prdata = 32'(modulus);
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(1);
    end else if (psel && penable && pwrite && paddr == 2'(RegModulus * 4)) begin
      modulus <= pwdata[W-1:0];
    end
  end

  // one restoring step
  logic [W:0] shifted, diff;
  logic ge;
  assign shifted = {dr, dd[W-1]};
  assign diff    = shifted - {1'b0, dv};
  assign ge      = (shifted >= {1'b0, dv});

  // modular double and add for the multiplier
  logic [W:0] dbl, add2;
  logic [W-1:0] accd, acca;
  assign dbl  = {acc, 1'b0};
  assign accd = (dbl >= {1'b0, m}) ? W'(dbl - {1'b0, m}) : dbl[W-1:0];
  assign add2 = {1'b0, accd} + {1'b0, qgm};
  assign acca = (add2 >= {1'b0, m}) ? W'(add2 - {1'b0, m}) : add2[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      solution  <= '0;
    end else begin
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            p <= multiplier; q <= target; m <= modulus;
            r0 <= target; r1 <= modulus;
            phase <= 1'b0;
            if (modulus == '0) begin
              acc <= '0; neg <= 1'b0; state <= ST_DONE;
            end else begin
              state <= ST_GCD;
            end
          end
        end
        ST_GCD: begin
          // gcd(q, m) first, then gcd(p, that)
          if (r1 == '0) begin
            if (!phase) begin
              r0 <= p; r1 <= r0; phase <= 1'b1;
            end else begin
              dd <= p; dv <= r0; dr <= '0; cnt <= CW'(W);
              op <= OP_RED_P; state <= ST_DIV;
            end
          end else begin
            dd <= r0; dv <= r1; dr <= '0; cnt <= CW'(W);
            op <= OP_GCD; state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt != '0) begin
            dr <= ge ? diff[W-1:0] : shifted[W-1:0];
            dd <= {dd[W-2:0], ge};
            // quotient times s1, built from the quotient bits as they come out
            prod <= {prod[W:0], 1'b0} + (ge ? s1 : '0);
            cnt <= cnt - 1'b1;
          end else begin
            unique case (op)
              OP_GCD: begin
                r0 <= r1; r1 <= dr; state <= ST_GCD;
              end
              // divisor g stays in dv for the three reductions
              OP_RED_P: begin
                r0 <= dd; dd <= m; dr <= '0; cnt <= CW'(W); op <= OP_RED_M;
              end
              OP_RED_M: begin
                r1 <= dd; dd <= q; dr <= '0; cnt <= CW'(W); op <= OP_RED_Q;
              end
              OP_RED_Q: begin
                dv <= m; dr <= '0; cnt <= CW'(W); op <= OP_QMOD;
              end
              OP_QMOD: begin
                qgm <= dr; s0 <= (W+2)'(1); s1 <= '0; state <= ST_EUC;
              end
              OP_EUC: begin
                r0 <= r1; r1 <= dr;
                s0 <= s1; s1 <= s0 - prod;
                state <= ST_EUC;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_EUC: begin
          if (r1 == '0) begin
            neg <= s0[W+1];
            mag <= s0[W+1] ? W'(-s0) : W'(s0);
            acc <= '0; cnt <= CW'(W); state <= ST_MUL;
          end else begin
            dd <= r0; dv <= r1; dr <= '0; prod <= '0; cnt <= CW'(W);
            op <= OP_EUC; state <= ST_DIV;
          end
        end
        ST_MUL: begin
          if (cnt != '0) begin
            acc <= mag[W-1] ? acca : accd;
            mag <= {mag[W-2:0], 1'b0};
            cnt <= cnt - 1'b1;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            solution <= (neg && acc != '0) ? m - acc : acc;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(solution)) else $error("result dropped");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> dv != '0) else $error("divide by zero");
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> acc < m) else $error("accumulator out of range");

endmodule
